/* rtl/core/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg : shared types and constants for the fall threshold detector
// Register indexes, fixed datapath widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_THR = 2'd1;

    localparam int THR_W      = 16;
    localparam int ANG_W      = 14;
    localparam int ANG_MAX    = 9000;
    localparam int THR_MAG_RST = 24590;
    localparam int THR_ANG_RST = 6000;

    // guarded radicand of the y/z root is always 62 bits wide
    localparam int YRAD_W     = 62;
    localparam int YROOT_W    = YRAD_W / 2;
    localparam int CV_W       = 34;   // CORDIC x/y vector width
    localparam int CZ_W       = 26;   // CORDIC angle accumulator width
    localparam int ATAN_N     = 24;

    // atan(2^-i) in 1/25600 degree
    localparam logic [20:0] ATAN_TAB [0:ATAN_N-1] = '{
        21'd1152000, 21'd680065, 21'd359328, 21'd182400, 21'd91554, 21'd45822,
        21'd22916,   21'd11459,  21'd5730,   21'd2865,   21'd1432,  21'd716,
        21'd358,     21'd179,    21'd90,     21'd45,     21'd22,    21'd11,
        21'd6,       21'd3,      21'd1,      21'd1,      21'd0,     21'd0
    };

    typedef struct packed {
        logic impact;
        logic yz_zero;
    } afd_tag_t;

endpackage

/* rtl/core/afd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// afd_sqrt_cell : one bit of a pipelined integer square root
// Brings down two radicand bits, tries the next root bit, keeps remainder.
// ----------------------------------------------------------------------------
module afd_sqrt_cell #(
    parameter int RAD_W = 32
) (
    input  logic                 aclk,
    input  logic                 adv,
    input  logic [RAD_W-1:0]     rad_in,
    input  logic [RAD_W/2+1:0]   rem_in,
    input  logic [RAD_W/2-1:0]   root_in,
    output logic [RAD_W-1:0]     rad_out,
    output logic [RAD_W/2+1:0]   rem_out,
    output logic [RAD_W/2-1:0]   root_out
);
    localparam int RW = RAD_W / 2;

    logic [RW+1:0]    cur;
    logic [RW+1:0]    trial;
    logic             take;
    logic [RAD_W-1:0] rad_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;

    assign cur   = {rem_in[RW-1:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_reg  <= {rad_in[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (cur - trial) : cur;
            root_reg <= {root_in[RW-2:0], take};
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

/* rtl/core/afd_cordic_cell.sv */
// ----------------------------------------------------------------------------
// afd_cordic_cell : one vectoring micro-rotation
// Rotates towards the x axis by atan(2^-IDX) and tracks the angle.
// ----------------------------------------------------------------------------
module afd_cordic_cell
    import afd_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic signed [CV_W-1:0] x_in,
    input  logic signed [CV_W-1:0] y_in,
    input  logic signed [CZ_W-1:0] z_in,
    output logic signed [CV_W-1:0] x_out,
    output logic signed [CV_W-1:0] y_out,
    output logic signed [CZ_W-1:0] z_out
);
    logic signed [CV_W-1:0] xs;
    logic signed [CV_W-1:0] ys;
    logic signed [CZ_W-1:0] a;
    logic signed [CV_W-1:0] x_reg;
    logic signed [CV_W-1:0] y_reg;
    logic signed [CZ_W-1:0] z_reg;

    assign xs = x_in >>> IDX;
    assign ys = y_in >>> IDX;
    assign a  = $signed({{(CZ_W-21){1'b0}}, ATAN_TAB[IDX]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (y_in > 0) begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + a;
            end else begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - a;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

/* rtl/core/accel_fall_threshold_detect_unit.sv */
// ----------------------------------------------------------------------------
// accel_fall_threshold_detect_unit : accelerometer fall threshold detector
// Magnitude, tilt angle and impact/tilt/fall flags per three-axis sample.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_      | in  | s_tvalid/s_tready   | s_tdata: x, y, z axes
//  m_      | out | m_tvalid/m_tready   | m_tdata: magnitude, angle, flags
//  cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One word per cycle while the output is not stalled; the path runs through
//  squares, sums, the 31 root cells of the guarded y/z root, CORDIC cells, output.
//  aresetn (synchronous) clears valid bits and loads default thresholds.
//  A stalled output word freezes the whole chain; s_tready follows it.
// ----------------------------------------------------------------------------
module accel_fall_threshold_detect_unit
    import afd_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // x_axis, y_axis, z_axis (lowest first), zero padded
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // magnitude, tilt_angle, impact_flag, tilt_flag, fall_flag, zero padded
    output logic [((SAMPLE_BITS+17+7)/8)*8-1:0] m_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [THR_W-1:0]             cfg_data
);
    localparam int S     = SAMPLE_BITS;
    localparam int N     = CORDIC_STAGES;
    localparam int GUARD = 31 - S;
    localparam int OUT_W = ((S+17+7)/8)*8;
    localparam int CMP_W = (2*S > 2*THR_W) ? 2*S : 2*THR_W;
    localparam int L     = 2 + YROOT_W + N;
    localparam int MDLY  = YROOT_W - S + N;

    logic adv;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // thresholds
    logic [THR_W-1:0]   mag_thr_reg;
    logic [ANG_W-1:0]   ang_thr_reg;
    logic [2*THR_W-1:0] thr_sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_thr_reg <= THR_W'(THR_MAG_RST);
            ang_thr_reg <= ANG_W'(THR_ANG_RST);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAG_THR: mag_thr_reg <= cfg_data;
                REG_ANG_THR: ang_thr_reg <= cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
        thr_sq_reg <= mag_thr_reg * mag_thr_reg;
    end

    // valid chain
    logic [L-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
    end

    // stage A: squares
    logic signed [S-1:0]   xi, yi, zi;
    logic signed [2*S-1:0] xx_reg, yy_reg, zz_reg;
    logic [S-1:0]          absx_reg;
    assign xi = s_tdata[S-1:0];
    assign yi = s_tdata[2*S-1:S];
    assign zi = s_tdata[3*S-1:2*S];

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg   <= xi * xi;
            yy_reg   <= yi * yi;
            zz_reg   <= zi * zi;
            absx_reg <= xi[S-1] ? $unsigned(-xi) : $unsigned(xi);
        end
    end

    // stage B: sums and impact compare
    logic [2*S-1:0] sum_c, yz_c;
    logic [2*S-1:0] sum_reg, yz_reg;
    logic [S-1:0]   absx_b_reg;
    afd_tag_t       tag_b_reg;
    assign yz_c  = $unsigned(yy_reg) + $unsigned(zz_reg);
    assign sum_c = yz_c + $unsigned(xx_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg           <= sum_c;
            yz_reg            <= yz_c;
            absx_b_reg        <= absx_reg;
            tag_b_reg.impact  <= CMP_W'(sum_c) > CMP_W'(thr_sq_reg);
            tag_b_reg.yz_zero <= (yz_c == '0);
        end
    end

    // square root chains
    logic [YRAD_W-1:0]  yrad [0:YROOT_W];
    logic [YROOT_W+1:0] yrem [0:YROOT_W];
    logic [YROOT_W-1:0] yroot[0:YROOT_W];
    logic [2*S-1:0]     mrad [0:S];
    logic [S+1:0]       mrem [0:S];
    logic [S-1:0]       mroot[0:S];

    assign yrad[0]  = {yz_reg, {(2*GUARD){1'b0}}};
    assign yrem[0]  = '0;
    assign yroot[0] = '0;
    assign mrad[0]  = sum_reg;
    assign mrem[0]  = '0;
    assign mroot[0] = '0;

    for (genvar k = 0; k < YROOT_W; k++) begin : g_ysqrt
        afd_sqrt_cell #(.RAD_W(YRAD_W)) u_cell (
            .aclk(aclk), .adv(adv),
            .rad_in(yrad[k]), .rem_in(yrem[k]), .root_in(yroot[k]),
            .rad_out(yrad[k+1]), .rem_out(yrem[k+1]), .root_out(yroot[k+1])
        );
    end

    for (genvar k = 0; k < S; k++) begin : g_msqrt
        afd_sqrt_cell #(.RAD_W(2*S)) u_cell (
            .aclk(aclk), .adv(adv),
            .rad_in(mrad[k]), .rem_in(mrem[k]), .root_in(mroot[k]),
            .rad_out(mrad[k+1]), .rem_out(mrem[k+1]), .root_out(mroot[k+1])
        );
    end

    // sidebands alongside the cells
    logic [S-1:0]   absx_d_reg [0:YROOT_W-1];
    afd_tag_t       tag_d_reg  [0:YROOT_W+N-1];
    logic [S-1:0]   mag_d_reg  [0:MDLY-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            absx_d_reg[0] <= absx_b_reg;
            tag_d_reg[0]  <= tag_b_reg;
            mag_d_reg[0]  <= mroot[S];
            for (int i = 1; i < YROOT_W; i++)
                absx_d_reg[i] <= absx_d_reg[i-1];
            for (int i = 1; i < YROOT_W + N; i++)
                tag_d_reg[i] <= tag_d_reg[i-1];
            for (int i = 1; i < MDLY; i++)
                mag_d_reg[i] <= mag_d_reg[i-1];
        end
    end

    // CORDIC chain
    logic signed [CV_W-1:0] cx [0:N];
    logic signed [CV_W-1:0] cy [0:N];
    logic signed [CZ_W-1:0] cz [0:N];

    assign cx[0] = $signed(CV_W'(absx_d_reg[YROOT_W-1]) << GUARD);
    assign cy[0] = $signed(CV_W'(yroot[YROOT_W]));
    assign cz[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        afd_cordic_cell #(.IDX(i)) u_cell (
            .aclk(aclk), .adv(adv),
            .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
            .x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1])
        );
    end

    // angle rounding, clamp and flags
    logic signed [CZ_W-1:0] zr;
    logic [ANG_W-1:0]       ang;
    afd_tag_t               tag_f;
    logic                   tilt;
    assign tag_f = tag_d_reg[YROOT_W+N-1];
    assign zr    = (cz[N] + CZ_W'(128)) >>> 8;

    always_comb begin
        if (tag_f.yz_zero || cz[N] < 0)
            ang = '0;
        else if (zr > CZ_W'(ANG_MAX))
            ang = ANG_W'(ANG_MAX);
        else
            ang = zr[ANG_W-1:0];
    end
    assign tilt = ang > ang_thr_reg;

    // output word
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= vld_reg[L-1];
        if (adv)
            m_tdata_reg <= OUT_W'({tag_f.impact | tilt, tilt, tag_f.impact, ang,
                                   mag_d_reg[MDLY-1]});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : fall threshold detector testbench
// Streams directed and random three-axis samples with bursty input and a
// stalling output. Every output word is checked against a local magnitude
// and CORDIC tilt predictor. Thresholds are rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
    import afd_pkg::*;

    localparam int SB        = 16;
    localparam int GUARD     = 31 - SB;
    localparam int STAGES    = 16;
    localparam int DRAIN     = 60;
    localparam int LIMIT     = 2000000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic        fall;
        logic        tilt;
        logic        impact;
        logic [13:0] angle;
        logic [15:0] mag;
    } fall_word_t;

    class fall_scoreboard;
        fall_word_t  pending[$];
        int          errors;
        logic [15:0] mag_thr;
        logic [13:0] ang_thr;
        longint      atan_lut[STAGES];

        function new();
            errors  = 0;
            mag_thr = 16'(THR_MAG_RST);
            ang_thr = 14'(THR_ANG_RST);
            atan_lut = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
                         5730, 2865, 1432, 716, 358, 179, 90, 45};
        endfunction

        function longint unsigned root_of(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [13:0] tilt_of(longint x, longint unsigned yz2);
            longint xv, yv, acc, nx, ny;
            if (yz2 == 0) return 14'd0;
            acc = 0;
            xv = (x < 0 ? -x : x) <<< GUARD;
            yv = longint'(root_of(yz2 << (2 * GUARD)));
            for (int i = 0; i < STAGES; i++) begin
                if (yv > 0) begin
                    nx = xv + (yv >>> i);
                    ny = yv - (xv >>> i);
                    acc += atan_lut[i];
                end else begin
                    nx = xv - (yv >>> i);
                    ny = yv + (xv >>> i);
                    acc -= atan_lut[i];
                end
                xv = nx;
                yv = ny;
            end
            if (acc < 0) return 14'd0;
            acc = (acc + 128) >>> 8;
            if (acc > ANG_MAX) acc = ANG_MAX;
            return 14'(acc);
        endfunction

        function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                                  logic signed [15:0] z);
            longint          xl, yl, zl;
            longint unsigned yz2, sum;
            fall_word_t      w;
            xl  = x;
            yl  = y;
            zl  = z;
            yz2 = longint'(yl * yl) + longint'(zl * zl);
            sum = longint'(xl * xl) + yz2;
            w.mag    = 16'(root_of(sum));
            w.angle  = tilt_of(xl, yz2);
            w.impact = sum > longint'(mag_thr) * longint'(mag_thr);
            w.tilt   = w.angle > ang_thr;
            w.fall   = w.impact | w.tilt;
            pending.push_back(w);
        endfunction

        function void check_word(logic [39:0] data);
            fall_word_t e, a;
            a = data[32:0];
            if (pending.size() == 0) begin
                $error("unexpected output word %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.mag !== e.mag) begin
                $error("magnitude: expected %0d, got %0d", e.mag, a.mag);
                errors++;
            end
            if (a.angle !== e.angle) begin
                $error("tilt_angle: expected %0d, got %0d", e.angle, a.angle);
                errors++;
            end
            if (a.impact !== e.impact) begin
                $error("impact_flag: expected %0b, got %0b", e.impact, a.impact);
                errors++;
            end
            if (a.tilt !== e.tilt) begin
                $error("tilt_flag: expected %0b, got %0b", e.tilt, a.tilt);
                errors++;
            end
            if (a.fall !== e.fall) begin
                $error("fall_flag: expected %0b, got %0b", e.fall, a.fall);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [47:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [39:0]          m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_data;

    fall_scoreboard sb = new();
    int  cycles = 0;
    bit  hold_go = 0;
    bit  gaps_on = 1;

    accel_fall_threshold_detect_unit i_dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (s_tvalid && s_tready) sb.note_sample(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
        if (m_tvalid && m_tready) sb.check_word(m_tdata);
    end

    initial begin
        @(posedge aclk);
        wait (cycles >= LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // receiver: stall pattern is redrawn at random from four modes; one long hold-off on request
    initial begin
        int mode, hold;
        mode = 0;
        hold = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_go && hold == 0) begin
                hold = 400;
                hold_go = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 7) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    int burst_left = 0;

    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if (gaps_on && s_tvalid) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (sb.pending.size() == 0);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MAG_THR) sb.mag_thr = val;
        else if (idx == REG_ANG_THR) sb.ang_thr = val[13:0];
    endtask

    function automatic logic [15:0] axis_value();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 60000)) - 30000);
            2: return 16'($signed($urandom_range(0, 8000)) - 4000);
            default: return 16'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_sample(16'(axis_value()), 16'd0, 16'd0);
            else
                send_sample(axis_value(), axis_value(), axis_value());
        end
    endtask

    initial begin
        aresetn   = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        cfg_valid = 0;
        cfg_index = REG_MAG_THR;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero vector, single axes, threshold edges
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'd0, 16'd0);
        send_sample(16'd0, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'h7fff);
        send_sample(16'd0, 16'd1, 16'd0);
        send_sample(16'd1, 16'd0, 16'd0);
        send_sample(16'hffff, 16'hffff, 16'hffff);
        send_sample(16'd24590, 16'd0, 16'd0);
        send_sample(16'd24591, 16'd0, 16'd0);
        send_sample(16'd1000, 16'd1732, 16'd0);
        send_sample(16'd1000, 16'd1733, 16'd0);
        send_sample(16'h5555, 16'haaaa, 16'h5555);
        send_sample(16'haaaa, 16'h5555, 16'haaaa);
        send_sample(16'd16393, 16'h8000, 16'h7fff);
        settle();

        random_run(200);
        settle();

        write_reg(REG_MAG_THR, 16'd0);
        write_reg(REG_ANG_THR, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'd1, 16'd0, 16'd0);
        send_sample(16'd5, 16'd0, 16'd1);
        // long output hold-off while input keeps coming
        hold_go = 1;
        random_run(150);
        settle();

        write_reg(REG_MAG_THR, 16'hffff);
        write_reg(REG_ANG_THR, 16'hffff);
        write_reg(REG_SPARE_A, 16'd7);
        write_reg(REG_SPARE_B, 16'd9);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'd0, 16'h7fff, 16'd0);
        gaps_on = 0;
        random_run(150);
        gaps_on = 1;
        settle();

        write_reg(REG_MAG_THR, 16'($urandom_range(10000, 40000)));
        write_reg(REG_ANG_THR, 16'd9000);
        random_run(100);
        settle();

        write_reg(REG_MAG_THR, 16'($urandom_range(0, 65535)));
        write_reg(REG_ANG_THR, 16'($urandom_range(0, 9000)));
        random_run(100);
        settle();

        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

/* accel_fall_threshold_detect_unit.f */
rtl/core/afd_pkg.sv
rtl/core/afd_sqrt_cell.sv
rtl/core/afd_cordic_cell.sv
rtl/core/accel_fall_threshold_detect_unit.sv
sim/tb.sv
